// File: sv/lpf_pkg.sv
// Shared types and constants for the length-prefixed packet FIFO.
// No dependencies; every other file except lpf_ram refers to this package by scoped names.
`default_nettype none

package lpf_pkg;

	localparam int unsigned STORE_BYTES_DEF = 65536;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned OP_W = 3;
	localparam int unsigned HDR_BYTES = 4;
	// smallest footprint of one packet: header plus one data byte
	localparam int unsigned MIN_PKT_BYTES = 5;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_OPEN = 3'd0,
		OP_WRITE_BYTE = 3'd1,
		OP_READ_OPEN  = 3'd2,
		OP_READ_BYTE  = 3'd3,
		OP_CANCEL     = 3'd4,
		OP_CLEAR      = 3'd5
	} op_e;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_FULL      = 3'd2,
		ST_CANCELLED = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_DROPPED   = 3'd5,
		ST_NO_PACKET = 3'd6
	} status_e;

	typedef struct packed {
		status_e           status;
		logic [LEN_W-1:0]  packet_length;
		logic              last;
		logic              data_ok;  // data_out comes from the byte store
	} result_t;

endpackage

`default_nettype wire

// File: sv/lpf_cmd_if.sv
// Command channel of the packet FIFO: valid/ready plus one op item.
// Depends on lpf_pkg for field widths.
`default_nettype none

interface lpf_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [lpf_pkg::OP_W-1:0]   op;
	logic [lpf_pkg::LEN_W-1:0]  length;
	logic [lpf_pkg::LEN_W-1:0]  max_length;
	logic [lpf_pkg::DATA_W-1:0] data_in;

	modport source (output valid, op, length, max_length, data_in, input ready);
	modport sink (input valid, op, length, max_length, data_in, output ready);
endinterface

`default_nettype wire

// File: sv/lpf_rsp_if.sv
// Response channel of the packet FIFO: valid/ready plus one result item.
// Depends on lpf_pkg for field widths.
`default_nettype none

interface lpf_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [lpf_pkg::LEN_W-1:0]  packet_length;
	logic [lpf_pkg::DATA_W-1:0] data_out;
	logic                       last;

	modport source (output valid, status, packet_length, data_out, last, input ready);
	modport sink (input valid, status, packet_length, data_out, last, output ready);
endinterface

`default_nettype wire

// File: sv/lpf_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No package dependency; used for the byte ring and the length queue.
`default_nettype none

module lpf_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/length_prefixed_packet_fifo.sv
// Top level of the length-prefixed packet FIFO over a byte ring.
// Depends on lpf_pkg, lpf_cmd_if, lpf_rsp_if and lpf_ram.
//
//   port  dir  handshake    payload
//   cmd   in   valid/ready  op, length, max_length, data_in
//   rsp   out  valid/ready  status, packet_length, data_out, last
//
// One item per cycle sustained while rsp is not stalled; an item passes the input
// register, then the result register, which is also the byte store's read register.
// The length header is kept in a separate length queue; the byte ring holds
// packet data bytes while header space is still accounted for in the counts.
// arst_n clears pointers, counts and flags; the memories need no clearing.
// A stalled rsp holds the result register; cmd.ready drops once the input
// register also holds an item.
`default_nettype none

module length_prefixed_packet_fifo #(
	parameter int unsigned STORE_BYTES = lpf_pkg::STORE_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lpf_cmd_if.sink    cmd,
	lpf_rsp_if.source  rsp
);

	localparam int unsigned PTR_W = $clog2(STORE_BYTES);
	localparam int unsigned CNT_W = $clog2(STORE_BYTES + 1);
	localparam int unsigned SUM_W = ((PTR_W > lpf_pkg::LEN_W) ? PTR_W : lpf_pkg::LEN_W) + 1;
	localparam int unsigned LQ_DEPTH = STORE_BYTES / lpf_pkg::MIN_PKT_BYTES;
	localparam int unsigned LQ_W = $clog2(LQ_DEPTH);
	localparam int unsigned LEN_W = lpf_pkg::LEN_W;
	localparam int unsigned DATA_W = lpf_pkg::DATA_W;

	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
			input logic [SUM_W-1:0] n);
		logic [SUM_W-1:0] s;
		s = SUM_W'(p) + n;
		if (s >= SUM_W'(STORE_BYTES)) begin
			s = s - SUM_W'(STORE_BYTES);
		end
		return s[PTR_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] cnt_sub(input logic [CNT_W-1:0] c,
			input logic [SUM_W-1:0] n);
		logic [SUM_W-1:0] d;
		d = SUM_W'(c) - n;
		return (SUM_W'(c) >= n) ? d[CNT_W-1:0] : '0;
	endfunction

	function automatic logic [LQ_W-1:0] lq_inc(input logic [LQ_W-1:0] i);
		return (i == LQ_W'(LQ_DEPTH - 1)) ? '0 : i + LQ_W'(1);
	endfunction

	// input register
	logic                     valid_s1;
	logic [lpf_pkg::OP_W-1:0] op_s1;
	logic [LEN_W-1:0]         length_s1;
	logic [LEN_W-1:0]         max_length_s1;
	logic [DATA_W-1:0]        data_in_s1;

	// FIFO state
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] reserved_q, committed_q;
	logic [LEN_W-1:0] wrem_q, rrem_q;
	logic             cancel_q;
	logic [LQ_W-1:0]  lq_wr_q, lq_rd_q;

	// next state
	logic [PTR_W-1:0] wp_c, rp_c;
	logic [CNT_W-1:0] reserved_c, committed_c;
	logic [LEN_W-1:0] wrem_c, rrem_c;
	logic             cancel_c;
	logic [LQ_W-1:0]  lq_wr_c, lq_rd_c, lq_rd_next;
	logic             mem_we_c, lq_we_c;

	// result register
	logic                 rsp_valid_q;
	lpf_pkg::result_t     res_c, res_q;
	logic [DATA_W-1:0]    store_rdata;

	// length queue head
	logic [LEN_W-1:0] lq_rdata, lq_head, byp_len_q;
	logic             byp_q, byp_hit;

	logic adv;

	assign adv = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1         <= cmd.op;
			length_s1     <= cmd.length;
			max_length_s1 <= cmd.max_length;
			data_in_s1    <= cmd.data_in;
		end
	end

	assign lq_head = byp_q ? byp_len_q : lq_rdata;

	always_comb begin
		logic [SUM_W-1:0] need;
		logic [SUM_W-1:0] free;
		logic [PTR_W-1:0] rp_a, rp_b;
		logic [CNT_W-1:0] res_a, com_a, res_b, com_b;
		logic [LEN_W-1:0] plen;

		wp_c        = wp_q;
		rp_c        = rp_q;
		reserved_c  = reserved_q;
		committed_c = committed_q;
		wrem_c      = wrem_q;
		rrem_c      = rrem_q;
		cancel_c    = cancel_q;
		lq_wr_c     = lq_wr_q;
		lq_rd_c     = lq_rd_q;
		mem_we_c    = 1'b0;
		lq_we_c     = 1'b0;
		res_c       = '{status: lpf_pkg::ST_OK, packet_length: '0, last: 1'b0,
			data_ok: 1'b0};

		need  = SUM_W'(length_s1) + SUM_W'(lpf_pkg::HDR_BYTES);
		free  = SUM_W'(STORE_BYTES) - SUM_W'(reserved_q);
		// discard the unread rest of a partly read packet first
		rp_a  = ptr_adv(rp_q, SUM_W'(rrem_q));
		res_a = cnt_sub(reserved_q, SUM_W'(rrem_q));
		com_a = cnt_sub(committed_q, SUM_W'(rrem_q));
		rp_b  = ptr_adv(rp_a, SUM_W'(lpf_pkg::HDR_BYTES));
		res_b = cnt_sub(res_a, SUM_W'(lpf_pkg::HDR_BYTES));
		com_b = cnt_sub(com_a, SUM_W'(lpf_pkg::HDR_BYTES));
		plen  = (SUM_W'(lq_head) > SUM_W'(com_b)) ? LEN_W'(com_b) : lq_head;

		unique case (op_s1)
			lpf_pkg::OP_WRITE_OPEN: begin
				if (length_s1 == '0) begin
					res_c.status = lpf_pkg::ST_INVALID;
				end else if (cancel_q) begin
					res_c.status = lpf_pkg::ST_CANCELLED;
				end else if (wrem_q != '0) begin
					res_c.status = lpf_pkg::ST_FULL;
				end else if (need > SUM_W'(STORE_BYTES)) begin
					res_c.status = lpf_pkg::ST_INVALID;
				end else if (free < need) begin
					res_c.status = lpf_pkg::ST_FULL;
				end else begin
					wp_c       = ptr_adv(wp_q, SUM_W'(lpf_pkg::HDR_BYTES));
					reserved_c = CNT_W'(SUM_W'(reserved_q) + need);
					wrem_c     = length_s1;
					lq_we_c    = 1'b1;
					lq_wr_c    = lq_inc(lq_wr_q);
				end
			end
			lpf_pkg::OP_WRITE_BYTE: begin
				if (wrem_q == '0) begin
					res_c.status = lpf_pkg::ST_NO_PACKET;
				end else if (cancel_q) begin
					res_c.status = lpf_pkg::ST_CANCELLED;
				end else begin
					mem_we_c = 1'b1;
					wp_c     = ptr_adv(wp_q, SUM_W'(1));
					wrem_c   = wrem_q - LEN_W'(1);
					if (wrem_q == LEN_W'(1)) begin
						res_c.last  = 1'b1;
						committed_c = reserved_q;
					end
				end
			end
			lpf_pkg::OP_READ_OPEN: begin
				if (cancel_q) begin
					res_c.status = lpf_pkg::ST_CANCELLED;
				end else begin
					rp_c        = rp_a;
					reserved_c  = res_a;
					committed_c = com_a;
					rrem_c      = '0;
					if (com_a < CNT_W'(lpf_pkg::HDR_BYTES)) begin
						res_c.status = lpf_pkg::ST_EMPTY;
					end else begin
						lq_rd_c             = lq_inc(lq_rd_q);
						res_c.packet_length = plen;
						if (plen > max_length_s1) begin
							res_c.status = lpf_pkg::ST_DROPPED;
							rp_c         = ptr_adv(rp_b, SUM_W'(plen));
							reserved_c   = cnt_sub(res_b, SUM_W'(plen));
							committed_c  = cnt_sub(com_b, SUM_W'(plen));
						end else begin
							rp_c        = rp_b;
							reserved_c  = res_b;
							committed_c = com_b;
							rrem_c      = plen;
						end
					end
				end
			end
			lpf_pkg::OP_READ_BYTE: begin
				if (rrem_q == '0) begin
					res_c.status = lpf_pkg::ST_NO_PACKET;
				end else if (cancel_q) begin
					res_c.status = lpf_pkg::ST_CANCELLED;
				end else begin
					res_c.data_ok = 1'b1;
					rp_c          = ptr_adv(rp_q, SUM_W'(1));
					reserved_c    = cnt_sub(reserved_q, SUM_W'(1));
					committed_c   = cnt_sub(committed_q, SUM_W'(1));
					rrem_c        = rrem_q - LEN_W'(1);
					res_c.last    = (rrem_q == LEN_W'(1));
				end
			end
			lpf_pkg::OP_CANCEL: begin
				cancel_c = 1'b1;
			end
			lpf_pkg::OP_CLEAR: begin
				wp_c        = '0;
				rp_c        = '0;
				reserved_c  = '0;
				committed_c = '0;
				wrem_c      = '0;
				rrem_c      = '0;
				cancel_c    = 1'b0;
				lq_wr_c     = '0;
				lq_rd_c     = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			reserved_q  <= '0;
			committed_q <= '0;
			wrem_q      <= '0;
			rrem_q      <= '0;
			cancel_q    <= 1'b0;
			lq_wr_q     <= '0;
			lq_rd_q     <= '0;
		end else if (adv) begin
			wp_q        <= wp_c;
			rp_q        <= rp_c;
			reserved_q  <= reserved_c;
			committed_q <= committed_c;
			wrem_q      <= wrem_c;
			rrem_q      <= rrem_c;
			cancel_q    <= cancel_c;
			lq_wr_q     <= lq_wr_c;
			lq_rd_q     <= lq_rd_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp.ready) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	// byte ring: read data register doubles as the result stage for data_out
	lpf_ram #(
		.DEPTH (STORE_BYTES),
		.WIDTH (DATA_W)
	) u_store (
		.clk   (clk),
		.we    (adv && mem_we_c),
		.waddr (wp_q),
		.wdata (data_in_s1),
		.re    (adv),
		.raddr (rp_q),
		.rdata (store_rdata)
	);

	// length queue: head entry is re-read every cycle at the next read index,
	// with a bypass when that entry is written at the same edge
	assign lq_rd_next = adv ? lq_rd_c : lq_rd_q;
	assign byp_hit    = adv && lq_we_c && (lq_wr_q == lq_rd_next);

	lpf_ram #(
		.DEPTH (LQ_DEPTH),
		.WIDTH (LEN_W)
	) u_lenq (
		.clk   (clk),
		.we    (adv && lq_we_c),
		.waddr (lq_wr_q),
		.wdata (length_s1),
		.re    (1'b1),
		.raddr (lq_rd_next),
		.rdata (lq_rdata)
	);

	always_ff @(posedge clk) begin
		byp_q     <= byp_hit;
		byp_len_q <= length_s1;
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = res_q.status;
	assign rsp.packet_length = res_q.packet_length;
	assign rsp.data_out      = res_q.data_ok ? store_rdata : '0;
	assign rsp.last          = res_q.last;

	a_commit_when_no_open: assert property (@(posedge clk) disable iff (!arst_n)
		wrem_q == '0 |-> committed_q == reserved_q)
		else $error("committed count differs from reserved with no packet open");

	a_commit_le_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		committed_q <= reserved_q)
		else $error("committed count exceeds reserved count");

	a_read_within_commit: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(rrem_q) <= SUM_W'(committed_q))
		else $error("read remainder exceeds committed bytes");

	a_stall_only_on_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (rsp.valid && !rsp.ready))
		else $error("cmd stalled without a stalled rsp");

	a_last_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.last) |-> (rsp.status == lpf_pkg::ST_OK))
		else $error("last mark on a failed item");

endmodule

`default_nettype wire
